### src/svr_pkg.sv
// Shared types, codes and constants for the stepper velocity ramp block.
`default_nettype none
package svr_pkg;

  // Motor count and index width (index is a single bit for two motors)
  localparam int unsigned MotorCount = 2;
  localparam int unsigned MotorW     = 1;

  // Field widths
  localparam int unsigned VelW   = 16;
  localparam int unsigned StepW  = 15;
  localparam int unsigned RateW  = 32;
  localparam int unsigned CmpW   = 16;
  localparam int unsigned CntW   = 5;

  // Register reset values
  localparam logic [StepW-1:0] RampStepReset = 15'd26;
  localparam logic [RateW-1:0] RateReset     = 32'd16084954;

  // Saturated compare value
  localparam logic [CmpW-1:0] CmpMax = 16'hFFFF;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_RAMP  = 2'd1,
    OP_APPLY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_RAMP_STEP = 1'b0,
    CFG_RATE      = 1'b1
  } cfg_idx_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic update;
    logic div_step;
    logic load_out;
  } svr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;
  } svr_sts_t;

endpackage
`default_nettype wire

### src/svr_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface svr_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [svr_pkg::MotorW-1:0]    motor_index;
  logic signed [svr_pkg::VelW-1:0] velocity;

  modport source (output valid, opcode, motor_index, velocity, input ready);
  modport sink   (input valid, opcode, motor_index, velocity, output ready);
endinterface

interface svr_out_if;
  logic                            valid;
  logic                            ready;
  logic [svr_pkg::MotorW-1:0]      motor_out;
  logic [svr_pkg::CmpW-1:0]        compare_value;
  logic                            running;
  logic signed [svr_pkg::VelW-1:0] present_velocity;

  modport source (output valid, motor_out, compare_value, running, present_velocity,
                  input ready);
  modport sink   (input valid, motor_out, compare_value, running, present_velocity,
                  output ready);
endinterface
`default_nettype wire

### src/svr_ctrl.sv
// Controller state machine: item intake, divider sequencing and result hand-off.
`default_nettype none
module svr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  input  wire svr_pkg::svr_sts_t sts_i,
  output svr_pkg::svr_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_UPDATE = 4'b0010,
    S_DIV    = 4'b0100,
    S_WAIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Decode commands from the current state
  always_comb begin
    cmd_o          = '0;
    cmd_o.latch    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.update   = (state_q == S_UPDATE);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.load_out = (state_q == S_WAIT) && (!out_valid_q || out_ready_i);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Advance the sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_UPDATE;
      S_UPDATE: state_d = S_DIV;
      S_DIV:    if (sts_i.div_last) state_d = S_WAIT;
      S_WAIT:   if (cmd_o.load_out) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Hold the result beat until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

### src/svr_datapath.sv
// Datapath: config registers, velocity state, ramp step, serial divider, result register.
`default_nettype none
module svr_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire svr_pkg::svr_cmd_t               cmd_i,
  output svr_pkg::svr_sts_t                    sts_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [0:0]                      cfg_idx_i,
  input  wire logic [svr_pkg::RateW-1:0]       cfg_data_i,
  input  wire logic [1:0]                      opcode_i,
  input  wire logic [svr_pkg::MotorW-1:0]      motor_i,
  input  wire logic signed [svr_pkg::VelW-1:0] velocity_i,
  output logic [svr_pkg::MotorW-1:0]           motor_o,
  output logic [svr_pkg::CmpW-1:0]             compare_o,
  output logic                                 running_o,
  output logic signed [svr_pkg::VelW-1:0]      present_vel_o
);

  // Configuration
  logic [svr_pkg::StepW-1:0] ramp_step_q;
  logic [svr_pkg::RateW-1:0] rate_q;

  // Per-motor velocity state
  logic signed [svr_pkg::VelW-1:0] cur_q [svr_pkg::MotorCount];
  logic signed [svr_pkg::VelW-1:0] tgt_q [svr_pkg::MotorCount];

  // Latched item
  svr_pkg::op_e                    op_q;
  logic [svr_pkg::MotorW-1:0]      mot_q;
  logic signed [svr_pkg::VelW-1:0] vin_q;

  // Working velocity and divider
  logic signed [svr_pkg::VelW-1:0] vel_q;
  logic                            pos_q;
  logic [svr_pkg::RateW-1:0]       dvd_q;
  logic [svr_pkg::VelW-1:0]        rem_q;
  logic [svr_pkg::StepW-1:0]       dvs_q;
  logic [svr_pkg::CntW-1:0]        cnt_q;

  // Output register
  logic [svr_pkg::MotorW-1:0]      mot_out_q;
  logic [svr_pkg::CmpW-1:0]        cmp_out_q;
  logic                            run_out_q;
  logic signed [svr_pkg::VelW-1:0] vel_out_q;

  // Ramp and update logic
  logic signed [svr_pkg::VelW-1:0] cur_sel, tgt_sel, ramp_vel, new_cur, new_tgt;
  logic signed [svr_pkg::VelW:0]   delta;
  logic [svr_pkg::VelW:0]          mag;
  logic signed [svr_pkg::VelW:0]   step_ext;

  always_comb begin
    cur_sel  = cur_q[mot_q];
    tgt_sel  = tgt_q[mot_q];
    delta    = {tgt_sel[svr_pkg::VelW-1], tgt_sel} - {cur_sel[svr_pkg::VelW-1], cur_sel};
    mag      = delta[svr_pkg::VelW] ? $unsigned(-delta) : $unsigned(delta);
    step_ext = $signed({2'b00, ramp_step_q});
    if (mag <= $unsigned(step_ext)) begin
      ramp_vel = tgt_sel;
    end else if (delta[svr_pkg::VelW]) begin
      ramp_vel = svr_pkg::VelW'({cur_sel[svr_pkg::VelW-1], cur_sel} - step_ext);
    end else begin
      ramp_vel = svr_pkg::VelW'({cur_sel[svr_pkg::VelW-1], cur_sel} + step_ext);
    end
    new_cur = cur_sel;
    new_tgt = tgt_sel;
    case (op_q)
      svr_pkg::OP_SET:   new_tgt = vin_q;
      svr_pkg::OP_RAMP:  new_cur = ramp_vel;
      svr_pkg::OP_APPLY: begin
        new_tgt = vin_q;
        new_cur = vin_q;
      end
      default: ;
    endcase
  end

  // Restoring divide step: one quotient bit per cycle
  logic [svr_pkg::VelW:0]   rem_sh;
  logic                     q_bit;
  logic [svr_pkg::VelW-1:0] rem_nx;

  always_comb begin
    rem_sh = {rem_q, dvd_q[svr_pkg::RateW-1]};
    q_bit  = (rem_sh >= {2'b00, dvs_q});
    rem_nx = q_bit ? svr_pkg::VelW'(rem_sh - {2'b00, dvs_q})
                   : svr_pkg::VelW'(rem_sh);
  end

  assign sts_o.div_last = (cnt_q == {svr_pkg::CntW{1'b1}});

  // Saturate the quotient; stopped for zero or negative velocity
  logic [svr_pkg::CmpW-1:0] cmp_val;

  always_comb begin
    if (!pos_q) begin
      cmp_val = '0;
    end else if (dvd_q[svr_pkg::RateW-1:svr_pkg::CmpW] != '0) begin
      cmp_val = svr_pkg::CmpMax;
    end else begin
      cmp_val = dvd_q[svr_pkg::CmpW-1:0];
    end
  end

  // Configuration and velocity state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q <= svr_pkg::RampStepReset;
      rate_q      <= svr_pkg::RateReset;
      for (int i = 0; i < svr_pkg::MotorCount; i++) begin
        cur_q[i] <= '0;
        tgt_q[i] <= '0;
      end
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (svr_pkg::cfg_idx_e'(cfg_idx_i))
          svr_pkg::CFG_RAMP_STEP: ramp_step_q <= cfg_data_i[svr_pkg::StepW-1:0];
          svr_pkg::CFG_RATE:      rate_q      <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        cur_q[mot_q] <= new_cur;
        tgt_q[mot_q] <= new_tgt;
        cnt_q        <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Item latch, divider and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= svr_pkg::op_e'(opcode_i);
      mot_q <= motor_i;
      vin_q <= velocity_i;
    end
    if (cmd_i.update) begin
      vel_q <= new_cur;
      pos_q <= !new_cur[svr_pkg::VelW-1] && (new_cur != '0);
      dvd_q <= rate_q;
      rem_q <= '0;
      dvs_q <= new_cur[svr_pkg::StepW-1:0];
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[svr_pkg::RateW-2:0], q_bit};
      rem_q <= rem_nx;
    end
    if (cmd_i.load_out) begin
      mot_out_q <= mot_q;
      cmp_out_q <= cmp_val;
      run_out_q <= (cmp_val != '0);
      vel_out_q <= vel_q;
    end
  end

  assign motor_o       = mot_out_q;
  assign compare_o     = cmp_out_q;
  assign running_o     = run_out_q;
  assign present_vel_o = vel_out_q;

endmodule
`default_nettype wire

### src/stepper_velocity_ramp_rate.sv
// An accepted item runs through an update step, the divide steps and a result register load.
// The 32-step bit-serial restoring divider holds one item; the next is taken after its load.
// A new item is taken while the previous result beat still waits in the output register.
// Reset (rst_ni low, asynchronous): velocities and targets clear to zero, ramp_step
// returns to 26, rate_constant to 16084954, no result is pending.
// Top level: two-motor stepper velocity ramp and timer compare computation.
`default_nettype none
module stepper_velocity_ramp_rate (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  svr_in_if.sink                         item_i,
  svr_out_if.source                      result_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [0:0]                cfg_idx_i,
  input  wire logic [svr_pkg::RateW-1:0] cfg_data_i
);

  svr_pkg::svr_cmd_t cmd;
  svr_pkg::svr_sts_t sts;

  // Sequence items through the datapath
  svr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Compute velocity update and compare value
  svr_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (item_i.opcode),
    .motor_i       (item_i.motor_index),
    .velocity_i    (item_i.velocity),
    .motor_o       (result_o.motor_out),
    .compare_o     (result_o.compare_value),
    .running_o     (result_o.running),
    .present_vel_o (result_o.present_velocity)
  );

endmodule
`default_nettype wire

### src/svr_checker.sv
// Port-level checker for the stepper velocity ramp block, bound to the top level.
`default_nettype none
module svr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_motor,
  input wire logic [15:0] out_compare,
  input wire logic        out_running,
  input wire logic [15:0] out_velocity
);

  // Stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Stalled result payload holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable({out_motor, out_compare, out_running, out_velocity}))
    else $error("result payload changed while stalled");

  // One item at a time: intake closes after an accepted beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // Run flag follows the compare value
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_running == (out_compare != 16'd0)))
    else $error("running flag disagrees with compare value");

  // A running motor has positive velocity
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_running |-> !out_velocity[15] && (out_velocity != 16'd0))
    else $error("running reported for non-positive velocity");

endmodule

bind stepper_velocity_ramp_rate svr_checker u_svr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (item_i.valid),
  .in_ready     (item_i.ready),
  .out_valid    (result_o.valid),
  .out_ready    (result_o.ready),
  .out_motor    (result_o.motor_out),
  .out_compare  (result_o.compare_value),
  .out_running  (result_o.running),
  .out_velocity (result_o.present_velocity)
);
`default_nettype wire
